// ----- src/huffman_bit_serial_decoder_unit_defines.svh -----
// ----------------------------------------------------------------------------
// huffman bit-serial decoder assertion macros
// shared property wrappers for the port-level checker
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_BIT_SERIAL_DECODER_UNIT_DEFINES_SVH
`define HUFFMAN_BIT_SERIAL_DECODER_UNIT_DEFINES_SVH

// same-cycle implication
`define HBSD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HBSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/hbsd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbsd_pkg
// shared types and constants of the huffman bit-serial decoder
// ----------------------------------------------------------------------------
package hbsd_pkg;

  localparam int unsigned IDX_W     = 9;  // index fields on the ports
  localparam int unsigned SYM_IN_W  = 8;  // symbol field of a node write
  localparam int unsigned SYM_OUT_W = 8;  // emitted symbol

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  typedef struct packed {
    logic                 valid;
    logic [SYM_OUT_W-1:0] symbol;
  } hbsd_result_t;

endpackage

// ----- src/huffman_bit_serial_decoder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_bit_serial_decoder_unit
// huffman tree-walk decoder, one code bit per request
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_stall_o): cmd_i selects a node write or a
//   decode of one code bit; node writes fill the table before it is walked
//   output channel (out_valid_o / out_stall_i): one symbol per leaf reached
//   config channel (cfg_valid_i / cfg_ready_o): root index, written while idle
// request flow
//   node write: no busy state; decode bit: ST_CHILD while the table read of
//   the child node runs (no busy state when the walk already stands on a
//   leaf node); first bit from the root after reset or a root write: ST_ROOT
//   first, whose extra table read refills the cached root node
// symbol output
//   a symbol is registered onto out_valid_o from the ST_CHILD read (or from
//   ST_ROOT when a refilled root is a leaf), or at the accepting edge when
//   the walk stands on a leaf; the output register frees the decoder at once
// reset
//   walk back at the root, root index 0, output empty; the table is not
//   cleared and needs no clearing pass
// stall
//   while a symbol waits under out_stall_i, in_stall_o stays high and the
//   walk holds its position
// ----------------------------------------------------------------------------
module huffman_bit_serial_decoder_unit
  import hbsd_pkg::*;
#(
  parameter int unsigned NODES       = 512,
  parameter int unsigned SYMBOL_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [IDX_W-1:0]     cfg_data_i,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 cmd_i,
  input  logic [IDX_W-1:0]     node_index_i,
  input  logic                 node_is_leaf_i,
  input  logic [SYM_IN_W-1:0]  leaf_symbol_i,
  input  logic [IDX_W-1:0]     left_child_i,
  input  logic [IDX_W-1:0]     right_child_i,
  input  logic                 code_bit_i,
  input  logic                 start_of_stream_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [SYM_OUT_W-1:0] symbol_o
);

  localparam int unsigned AW = $clog2(NODES);
  localparam int unsigned DW = 1 + SYMBOL_BITS + 2 * AW;

  logic                 busy;
  logic                 out_full;
  logic                 take;
  hbsd_result_t         res;
  logic                 out_valid_q, out_valid_d;
  logic [SYM_OUT_W-1:0] symbol_q;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [DW-1:0]        mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [DW-1:0]        mem_rdata;

  // output register holds a symbol the receiver has not taken
  assign out_full    = out_valid_q & out_stall_i;
  assign in_stall_o  = busy | out_full;
  assign cfg_ready_o = ~busy;
  assign take        = in_valid_i & ~in_stall_o;

  hbsd_walk_ctrl #(
    .NODES       (NODES),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_walk_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .take_i            (take),
    .cmd_i             (cmd_i),
    .node_index_i      (node_index_i),
    .node_is_leaf_i    (node_is_leaf_i),
    .leaf_symbol_i     (leaf_symbol_i),
    .left_child_i      (left_child_i),
    .right_child_i     (right_child_i),
    .code_bit_i        (code_bit_i),
    .start_of_stream_i (start_of_stream_i),
    .root_wr_i         (cfg_valid_i & cfg_ready_o),
    .root_value_i      (cfg_data_i),
    .out_full_i        (out_full),
    .busy_o            (busy),
    .res_o             (res),
    .mem_we_o          (mem_we),
    .mem_waddr_o       (mem_waddr),
    .mem_wdata_o       (mem_wdata),
    .mem_re_o          (mem_re),
    .mem_raddr_o       (mem_raddr),
    .mem_rdata_i       (mem_rdata)
  );

  hbsd_node_ram #(
    .DEPTH (NODES),
    .DW    (DW)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // load on a new symbol, drain when the receiver takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      symbol_q <= res.symbol;
    end
  end

  assign out_valid_o = out_valid_q;
  assign symbol_o    = symbol_q;

endmodule

// ----- src/hbsd_node_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbsd_node_ram
// node table: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module hbsd_node_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned DW    = 27
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DW-1:0]            wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DW-1:0]            rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/hbsd_walk_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbsd_walk_ctrl
// tree walk sequencer with cached root and current node
// ----------------------------------------------------------------------------
module hbsd_walk_ctrl
  import hbsd_pkg::*;
#(
  parameter int unsigned NODES       = 512,
  parameter int unsigned SYMBOL_BITS = 8,
  localparam int unsigned AW         = $clog2(NODES),
  localparam int unsigned DW         = 1 + SYMBOL_BITS + 2 * AW
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic                cmd_i,
  input  logic [IDX_W-1:0]    node_index_i,
  input  logic                node_is_leaf_i,
  input  logic [SYM_IN_W-1:0] leaf_symbol_i,
  input  logic [IDX_W-1:0]    left_child_i,
  input  logic [IDX_W-1:0]    right_child_i,
  input  logic                code_bit_i,
  input  logic                start_of_stream_i,
  input  logic                root_wr_i,
  input  logic [IDX_W-1:0]    root_value_i,
  input  logic                out_full_i,
  output logic                busy_o,
  output hbsd_result_t        res_o,
  output logic                mem_we_o,
  output logic [AW-1:0]       mem_waddr_o,
  output logic [DW-1:0]       mem_wdata_o,
  output logic                mem_re_o,
  output logic [AW-1:0]       mem_raddr_o,
  input  logic [DW-1:0]       mem_rdata_i
);

  localparam int unsigned RW     = IDX_W + 1;
  localparam int unsigned LEAF_B = DW - 1;
  localparam int unsigned SYM_LO = 2 * AW;

  typedef enum logic [1:0] {ST_IDLE, ST_ROOT, ST_CHILD} state_e;

  // index modulo NODES by restoring compare and subtract
  function automatic logic [AW-1:0] wrap_idx(input logic [IDX_W-1:0] v);
    logic [RW-1:0] r;
    r = {1'b0, v};
    for (int k = 7; k >= 0; k--) begin
      if ((NODES << k) < (1 << IDX_W)) begin
        if (int'(r) >= (NODES << k)) begin
          r = r - RW'(NODES << k);
        end
      end
    end
    return AW'(r);
  endfunction

  state_e        state_q, state_d;
  logic          at_root_q, at_root_d;
  logic [AW-1:0] walk_pos_q, walk_pos_d;
  logic [AW-1:0] root_q, root_d;
  logic          root_valid_q, root_valid_d;
  logic          bit_q, bit_d;
  logic [AW-1:0] child_q, child_d;
  logic [DW-1:0] cur_node_q, cur_node_d;
  logic [DW-1:0] root_node_q, root_node_d;

  logic [AW-1:0] wr_idx;
  logic [DW-1:0] wdata;
  logic          at_eff;
  logic [DW-1:0] step_node;
  logic          step_bit;
  logic [AW-1:0] step_child;

  assign wr_idx = wrap_idx(node_index_i);
  assign wdata  = {node_is_leaf_i, SYMBOL_BITS'(leaf_symbol_i),
                   wrap_idx(left_child_i), wrap_idx(right_child_i)};
  assign at_eff = at_root_q | start_of_stream_i;

  // node the step starts from: cached copy, or the root just fetched
  assign step_node  = (state_q == ST_ROOT) ? mem_rdata_i :
                      (at_eff ? root_node_q : cur_node_q);
  assign step_bit   = (state_q == ST_ROOT) ? bit_q : code_bit_i;
  assign step_child = step_bit ? step_node[AW-1:0] : step_node[2*AW-1:AW];

  always_comb begin
    state_d      = state_q;
    at_root_d    = at_root_q;
    walk_pos_d   = walk_pos_q;
    root_d       = root_q;
    root_valid_d = root_valid_q;
    bit_d        = bit_q;
    child_d      = child_q;
    cur_node_d   = cur_node_q;
    root_node_d  = root_node_q;
    mem_we_o     = 1'b0;
    mem_re_o     = 1'b0;
    mem_raddr_o  = root_q;
    res_o        = '0;

    case (state_q)
      ST_IDLE: begin
        if (take_i) begin
          if (cmd_i == CMD_WRITE) begin
            mem_we_o = 1'b1;
            // keep both cached nodes coherent with the table
            if (wr_idx == root_q) begin
              root_node_d  = wdata;
              root_valid_d = 1'b1;
            end
            if (!at_root_q && wr_idx == walk_pos_q) begin
              cur_node_d = wdata;
            end
          end else if (at_eff && !root_valid_q) begin
            mem_re_o    = 1'b1;
            mem_raddr_o = root_q;
            bit_d       = code_bit_i;
            at_root_d   = 1'b1;
            state_d     = ST_ROOT;
          end else if (step_node[LEAF_B]) begin
            res_o.valid  = 1'b1;
            res_o.symbol = SYM_OUT_W'(step_node[SYM_LO +: SYMBOL_BITS]);
            at_root_d    = 1'b1;
            walk_pos_d   = '0;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = step_child;
            child_d     = step_child;
            state_d     = ST_CHILD;
          end
        end
      end
      ST_ROOT: begin
        root_node_d  = mem_rdata_i;
        root_valid_d = 1'b1;
        if (step_node[LEAF_B]) begin
          if (!out_full_i) begin
            res_o.valid  = 1'b1;
            res_o.symbol = SYM_OUT_W'(step_node[SYM_LO +: SYMBOL_BITS]);
            at_root_d    = 1'b1;
            walk_pos_d   = '0;
            state_d      = ST_IDLE;
          end
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = step_child;
          child_d     = step_child;
          state_d     = ST_CHILD;
        end
      end
      ST_CHILD: begin
        if (mem_rdata_i[LEAF_B]) begin
          if (!out_full_i) begin
            res_o.valid  = 1'b1;
            res_o.symbol = SYM_OUT_W'(mem_rdata_i[SYM_LO +: SYMBOL_BITS]);
            at_root_d    = 1'b1;
            walk_pos_d   = '0;
            state_d      = ST_IDLE;
          end
        end else begin
          cur_node_d = mem_rdata_i;
          walk_pos_d = child_q;
          at_root_d  = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // a new root invalidates the cached root node
    if (root_wr_i) begin
      root_d       = wrap_idx(root_value_i);
      root_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      at_root_q    <= 1'b1;
      walk_pos_q   <= '0;
      root_q       <= '0;
      root_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      at_root_q    <= at_root_d;
      walk_pos_q   <= walk_pos_d;
      root_q       <= root_d;
      root_valid_q <= root_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q       <= bit_d;
    child_q     <= child_d;
    cur_node_q  <= cur_node_d;
    root_node_q <= root_node_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign mem_waddr_o = wr_idx;
  assign mem_wdata_o = wdata;

endmodule

// ----- src/hbsd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbsd_checker
// port-level checks of the huffman bit-serial decoder
// ----------------------------------------------------------------------------
`include "huffman_bit_serial_decoder_unit_defines.svh"

module hbsd_checker
  import hbsd_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cfg_ready_o,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 cmd_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [SYM_OUT_W-1:0] symbol_o
);

  // stalled symbol stays put
  `HBSD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(symbol_o), "symbol changed under stall")

  // a node write never produces a symbol
  `HBSD_ASSERT_NEXT(a_write_silent, clk_i, rst_ni,
    in_valid_i && !in_stall_o && cmd_i == CMD_WRITE && !out_valid_o,
    !out_valid_o, "node write produced a symbol")

  // a busy walk blocks new requests
  `HBSD_ASSERT_NOW(a_busy_stalls, clk_i, rst_ni, !cfg_ready_o, in_stall_o,
    "request taken while the walk is busy")

  // a symbol follows a decode request or an ongoing walk
  `HBSD_ASSERT_NOW(a_out_source, clk_i, rst_ni, $rose(out_valid_o),
    $past(in_stall_o) || $past(in_valid_i && cmd_i == CMD_DECODE),
    "symbol without a decode request")

endmodule

bind huffman_bit_serial_decoder_unit hbsd_checker u_hbsd_checker (.*);

// ----- dv/tb_huffman_bit_serial_decoder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_huffman_bit_serial_decoder_unit
// self-checking bench for the huffman tree-walk decoder: a scoreboard class
// keeps its own node table and walk state, predicts the symbol of every
// decode request that reaches a leaf, and checks each symbol leaving the
// output channel; node entries that a decode is about to read are written
// on demand, so the tree grows as the random bit stream walks into it
// ----------------------------------------------------------------------------
module tb_huffman_bit_serial_decoder_unit;
  import hbsd_pkg::*;

  localparam int unsigned NODE_COUNT = 512;
  localparam time         CLK_HALF   = 5ns;
  localparam int unsigned PHASES     = 8;
  localparam int unsigned PHASE_REQS = 190;

  // one request on the input channel, all fields as driven on the ports
  typedef struct {
    logic                cmd;
    logic [IDX_W-1:0]    index;
    logic                leaf;
    logic [SYM_IN_W-1:0] sym;
    logic [IDX_W-1:0]    left;
    logic [IDX_W-1:0]    right;
    logic                code;
    logic                sos;
  } walk_request_t;

  typedef struct {
    bit                 leaf;
    bit [SYM_IN_W-1:0]  sym;
    bit [IDX_W-1:0]     left;
    bit [IDX_W-1:0]     right;
  } tree_node_t;

  // --------------------------------------------------------------------------
  // scoreboard: shadow node table, walk state and the queue of due symbols
  // --------------------------------------------------------------------------
  class tree_walk_scoreboard;
    tree_node_t           nodes [NODE_COUNT];
    bit                   written [NODE_COUNT];
    bit [IDX_W-1:0]       root;
    bit [IDX_W-1:0]       walk_pos;
    bit                   at_root;
    logic [SYM_OUT_W-1:0] pending_symbols [$];
    int                   errors;

    function new();
      root     = '0;
      walk_pos = '0;
      at_root  = 1'b1;
      errors   = 0;
    endfunction

    function void set_root(bit [IDX_W-1:0] value);
      root = value;
    endfunction

    // append one due symbol at the tail of the queue
    function void queue_symbol(logic [SYM_OUT_W-1:0] s);
      pending_symbols.insert(pending_symbols.size(), s);
    endfunction

    // first table entry a decode of this bit would read before it is written,
    // -1 when every entry on the path is known
    function int missing_entry(bit code, bit sos);
      bit [IDX_W-1:0] pos;
      bit [IDX_W-1:0] child;
      pos = (sos || at_root) ? root : walk_pos;
      if (!written[pos]) return int'(pos);
      if (nodes[pos].leaf) return -1;
      child = code ? nodes[pos].right : nodes[pos].left;
      if (!written[child]) return int'(child);
      return -1;
    endfunction

    function void note_request(walk_request_t r);
      bit [IDX_W-1:0] pos;
      bit [IDX_W-1:0] child;
      if (r.cmd == CMD_WRITE) begin
        nodes[r.index].leaf  = r.leaf;
        nodes[r.index].sym   = r.sym;
        nodes[r.index].left  = r.left;
        nodes[r.index].right = r.right;
        written[r.index]     = 1'b1;
        return;
      end
      if (r.sos) at_root = 1'b1;
      pos = at_root ? root : walk_pos;
      // walk already standing on a leaf: emit it without a step
      if (nodes[pos].leaf) begin
        queue_symbol(nodes[pos].sym);
        at_root  = 1'b1;
        walk_pos = '0;
        return;
      end
      child = r.code ? nodes[pos].right : nodes[pos].left;
      if (nodes[child].leaf) begin
        queue_symbol(nodes[child].sym);
        at_root  = 1'b1;
        walk_pos = '0;
      end else begin
        walk_pos = child;
        at_root  = 1'b0;
      end
    endfunction

    function void check_symbol(logic [SYM_OUT_W-1:0] got);
      logic [SYM_OUT_W-1:0] want;
      if (pending_symbols.size() == 0) begin
        $error("symbol: expected none, got %0h", got);
        errors++;
        return;
      end
      want = pending_symbols.pop_front();
      if (got !== want) begin
        $error("symbol: expected %0h, got %0h", want, got);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // dut signals
  // --------------------------------------------------------------------------
  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [IDX_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 cmd_i;
  logic [IDX_W-1:0]     node_index_i;
  logic                 node_is_leaf_i;
  logic [SYM_IN_W-1:0]  leaf_symbol_i;
  logic [IDX_W-1:0]     left_child_i;
  logic [IDX_W-1:0]     right_child_i;
  logic                 code_bit_i;
  logic                 start_of_stream_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [SYM_OUT_W-1:0] symbol_o;

  tree_walk_scoreboard sb;

  // idle odds in percent, changed per phase
  int unsigned gap_pct;
  int unsigned stall_pct;

  huffman_bit_serial_decoder_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .cmd_i             (cmd_i),
    .node_index_i      (node_index_i),
    .node_is_leaf_i    (node_is_leaf_i),
    .leaf_symbol_i     (leaf_symbol_i),
    .left_child_i      (left_child_i),
    .right_child_i     (right_child_i),
    .code_bit_i        (code_bit_i),
    .start_of_stream_i (start_of_stream_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .symbol_o          (symbol_o)
  );

  initial clk_i = 1'b0;
  always #CLK_HALF clk_i = ~clk_i;

  // receiver: random back-pressure, changed at the falling edge
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // receiver: a symbol is taken when valid and not stalled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_symbol(symbol_o);
  end

  // --------------------------------------------------------------------------
  // sender tasks
  // --------------------------------------------------------------------------

  // every field but the command random; the fields a command ignores stay that way
  function automatic walk_request_t random_fields();
    walk_request_t r;
    r.cmd   = CMD_WRITE;
    r.index = IDX_W'($urandom_range(NODE_COUNT - 1));
    r.leaf  = 1'($urandom_range(1));
    r.sym   = SYM_IN_W'($urandom_range(255));
    r.left  = IDX_W'($urandom_range(NODE_COUNT - 1));
    r.right = IDX_W'($urandom_range(NODE_COUNT - 1));
    r.code  = 1'($urandom_range(1));
    r.sos   = 1'($urandom_range(1));
    return r;
  endfunction

  // optional idle gap, then hold the request until the decoder takes it
  task automatic send_request(walk_request_t r);
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    cmd_i             <= r.cmd;
    node_index_i      <= r.index;
    node_is_leaf_i    <= r.leaf;
    leaf_symbol_i     <= r.sym;
    left_child_i      <= r.left;
    right_child_i     <= r.right;
    code_bit_i        <= r.code;
    start_of_stream_i <= r.sos;
    in_valid_i        <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(r);
  endtask

  task automatic write_node(bit [IDX_W-1:0] idx, bit leaf, bit [SYM_IN_W-1:0] sym,
                            bit [IDX_W-1:0] left, bit [IDX_W-1:0] right);
    walk_request_t r;
    r       = random_fields();
    r.cmd   = CMD_WRITE;
    r.index = idx;
    r.leaf  = leaf;
    r.sym   = sym;
    r.left  = left;
    r.right = right;
    send_request(r);
  endtask

  task automatic decode_bit(bit code, bit sos);
    walk_request_t r;
    r      = random_fields();
    r.cmd  = CMD_DECODE;
    r.code = code;
    r.sos  = sos;
    send_request(r);
  endtask

  // fill in whatever the walk would read unwritten, then send the bit;
  // about 40 percent of the new nodes are leaves so symbols keep coming
  task automatic decode_on_known_tree(bit code, bit sos);
    int hole;
    hole = sb.missing_entry(code, sos);
    while (hole >= 0) begin
      write_node(IDX_W'(hole), ($urandom_range(99) < 40), SYM_IN_W'($urandom_range(255)),
                 IDX_W'($urandom_range(NODE_COUNT - 1)),
                 IDX_W'($urandom_range(NODE_COUNT - 1)));
      hole = sb.missing_entry(code, sos);
    end
    decode_bit(code, sos);
  endtask

  // sender goes quiet until every predicted symbol has been taken
  task automatic drain_symbols();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_symbols.size() != 0) @(posedge clk_i);
  endtask

  // root writes only with the decoder idle; the extra cycles cover a last
  // decode step that produced no symbol
  task automatic write_root(bit [IDX_W-1:0] value);
    drain_symbols();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_root(value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // noise write aimed now and then at the root or at the node the walk is on
  task automatic random_write();
    int unsigned      pick;
    bit [IDX_W-1:0]   idx;
    pick = $urandom_range(99);
    if (pick < 10)      idx = sb.root;
    else if (pick < 20) idx = sb.walk_pos;
    else                idx = IDX_W'($urandom_range(NODE_COUNT - 1));
    write_node(idx, 1'($urandom_range(1)), SYM_IN_W'($urandom_range(255)),
               IDX_W'($urandom_range(NODE_COUNT - 1)),
               IDX_W'($urandom_range(NODE_COUNT - 1)));
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    sb                = new();
    gap_pct           = 0;
    stall_pct         = 0;
    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_data_i        = '0;
    in_valid_i        = 1'b0;
    cmd_i             = CMD_WRITE;
    node_index_i      = '0;
    node_is_leaf_i    = 1'b0;
    leaf_symbol_i     = '0;
    left_child_i      = '0;
    right_child_i     = '0;
    code_bit_i        = 1'b0;
    start_of_stream_i = 1'b0;
    out_stall_i       = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // small tree under the reset root 0, with index and symbol extremes
    write_node(9'd0,   1'b0, 8'h00, 9'd1, 9'd511);
    write_node(9'd1,   1'b1, 8'h00, 9'd0, 9'd0);
    write_node(9'd511, 1'b0, 8'h00, 9'd2, 9'd3);
    write_node(9'd2,   1'b1, 8'hff, 9'd0, 9'd0);
    write_node(9'd3,   1'b1, 8'ha5, 9'd511, 9'd511);
    decode_bit(1'b0, 1'b0);
    decode_bit(1'b1, 1'b0);
    decode_bit(1'b0, 1'b0);
    decode_bit(1'b1, 1'b0);
    decode_bit(1'b1, 1'b0);
    // start-of-stream in the middle of a code restarts at the root
    decode_bit(1'b1, 1'b0);
    decode_bit(1'b0, 1'b1);
    // node under the walk turns into a leaf before the next bit
    decode_bit(1'b1, 1'b0);
    write_node(9'd511, 1'b1, 8'h3c, 9'd0, 9'd0);
    decode_bit(1'b0, 1'b0);
    // root that is a leaf: every bit gives the root symbol
    write_root(9'd511);
    decode_bit(1'b0, 1'b0);
    decode_bit(1'b1, 1'b1);
    // walk below the root keeps going across a root change
    write_root(9'd0);
    write_node(9'd511, 1'b0, 8'h00, 9'd2, 9'd3);
    decode_bit(1'b1, 1'b0);
    write_root(9'd1);
    decode_bit(1'b0, 1'b0);
    decode_bit(1'b0, 1'b0);

    // random phases, cycling through the idle patterns
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 54; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 54; end
        default: begin gap_pct = 30; stall_pct = 30; end
      endcase
      if (p == 0)      write_root(9'd0);
      else if (p == 1) write_root(9'd511);
      else             write_root(IDX_W'($urandom_range(NODE_COUNT - 1)));
      for (int i = 0; i < PHASE_REQS; i++) begin
        // mid-phase the sender waits for the output to run dry
        if (i == PHASE_REQS / 2) drain_symbols();
        if ($urandom_range(99) < 25) random_write();
        else decode_on_known_tree(1'($urandom_range(1)), ($urandom_range(99) < 10));
      end
    end

    drain_symbols();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_symbols.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #3ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
